>>> rtl/cl2u8_pkg.sv
`default_nettype none
package cl2u8_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       out_last;
      logic [2:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0] charset_form;
      logic       locator_utf16;
      logic       locator_little_endian;
   } cfg_type;

   typedef struct packed {
      logic [7:0] held_byte;
      logic       byte_parity;
      logic [9:0] pending_high;
      logic       have_high;
      logic [1:0] utf8_remaining;
      logic [2:0] second_rule;
      logic [2:0] sticky_error;
   } st_type;

   // up to four result items produced by one input beat
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      cnt;
      logic            data;
      logic            last;
      logic [2:0]      code;
   } grp_type;

   typedef enum logic [2:0] {
      MODE_UTF8     = 3'd0,
      MODE_BE       = 3'd1,
      MODE_LE       = 3'd2,
      MODE_BAD_FORM = 3'd6,
      MODE_BAD_LOC  = 3'd7
   } mode_type;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_ODD        = 3'd1;
   localparam logic [2:0] ERR_TRUNC_HIGH = 3'd2;
   localparam logic [2:0] ERR_BAD_LOW    = 3'd3;
   localparam logic [2:0] ERR_LONE_LOW   = 3'd4;
   localparam logic [2:0] ERR_BAD_UTF8   = 3'd5;
   localparam logic [2:0] ERR_BAD_FORM   = 3'd6;
   localparam logic [2:0] ERR_BAD_LOC    = 3'd7;

   // range rule for the second byte of a UTF-8 sequence
   localparam logic [2:0] RULE_NONE = 3'd0;
   localparam logic [2:0] RULE_ANY  = 3'd1;
   localparam logic [2:0] RULE_E0   = 3'd2;
   localparam logic [2:0] RULE_ED   = 3'd3;
   localparam logic [2:0] RULE_F0   = 3'd4;
   localparam logic [2:0] RULE_F4   = 3'd5;

   localparam logic [7:0] FORM_LOCATOR0 = 8'd0;
   localparam logic [7:0] FORM_LOCATOR1 = 8'd1;
   localparam logic [7:0] FORM_UTF16BE  = 8'd2;

   localparam logic [1:0] REG_FORM  = 2'd0;
   localparam logic [1:0] REG_UTF16 = 2'd1;
   localparam logic [1:0] REG_LE    = 2'd2;

   localparam logic [15:0] HIGH_LO = 16'hD800;
   localparam logic [15:0] HIGH_HI = 16'hDBFF;
   localparam logic [15:0] LOW_LO  = 16'hDC00;
   localparam logic [15:0] LOW_HI  = 16'hDFFF;
   localparam logic [10:0] PLANE1  = 11'h040;

endpackage
`default_nettype wire

>>> rtl/cl2u8_step.sv
`default_nettype none
module cl2u8_step (
   input  cl2u8_pkg::cfg_type cfg,
   input  cl2u8_pkg::st_type  st,
   input  cl2u8_pkg::req_type item,
   output cl2u8_pkg::st_type  st_nxt,
   output cl2u8_pkg::grp_type grp
);
   import cl2u8_pkg::*;

   mode_type    mode;
   logic [7:0]  b;
   logic [15:0] unit;
   logic        cp_emit;
   logic [20:0] cp;
   logic        u8_emit;
   logic        rule_ok;
   logic [2:0]  code;
   grp_type     gen;

   always_comb begin
      if (cfg.charset_form == FORM_UTF16BE) begin
         mode = MODE_BE;
      end else if (cfg.charset_form != FORM_LOCATOR0 && cfg.charset_form != FORM_LOCATOR1) begin
         mode = MODE_BAD_FORM;
      end else if (!cfg.locator_utf16 && cfg.locator_little_endian) begin
         mode = MODE_BAD_LOC;
      end else if (cfg.locator_utf16) begin
         mode = cfg.locator_little_endian ? MODE_LE : MODE_BE;
      end else begin
         mode = MODE_UTF8;
      end
   end

   assign b    = item.data_byte;
   assign unit = (mode == MODE_BE) ? {st.held_byte, b} : {b, st.held_byte};

   always_comb begin
      case (st.second_rule)
         RULE_E0: rule_ok = b inside {[8'hA0:8'hBF]};
         RULE_ED: rule_ok = b inside {[8'h80:8'h9F]};
         RULE_F0: rule_ok = b inside {[8'h90:8'hBF]};
         RULE_F4: rule_ok = b inside {[8'h80:8'h8F]};
         default: rule_ok = b inside {[8'h80:8'hBF]};
      endcase
   end

   always_comb begin
      st_nxt  = st;
      cp_emit = 1'b0;
      cp      = {5'd0, unit};
      u8_emit = 1'b0;
      if (st.sticky_error == ERR_NONE) begin
         if (mode == MODE_BAD_FORM) begin
            st_nxt.sticky_error = ERR_BAD_FORM;
         end else if (mode == MODE_BAD_LOC) begin
            st_nxt.sticky_error = ERR_BAD_LOC;
         end else if (mode != MODE_UTF8) begin
            if (!st.byte_parity) begin
               st_nxt.held_byte = b;
            end else if (st.have_high) begin
               st_nxt.have_high = 1'b0;
               if (!(unit inside {[LOW_LO:LOW_HI]})) begin
                  st_nxt.sticky_error = ERR_BAD_LOW;
               end else begin
                  cp_emit = 1'b1;
                  cp      = {st.pending_high + PLANE1, unit[9:0]};
               end
            end else if (unit inside {[HIGH_LO:HIGH_HI]}) begin
               st_nxt.pending_high = unit[9:0];
               st_nxt.have_high    = 1'b1;
            end else if (unit inside {[LOW_LO:LOW_HI]}) begin
               st_nxt.sticky_error = ERR_LONE_LOW;
            end else begin
               cp_emit = 1'b1;
            end
         end else if (st.utf8_remaining != 2'd0) begin
            if (!rule_ok) begin
               st_nxt.sticky_error = ERR_BAD_UTF8;
            end else begin
               st_nxt.second_rule    = RULE_NONE;
               st_nxt.utf8_remaining = st.utf8_remaining - 2'd1;
               u8_emit               = 1'b1;
            end
         end else begin
            u8_emit = 1'b1;
            if (b inside {[8'h00:8'h7F]}) begin
               u8_emit = 1'b1;
            end else if (b inside {[8'hC2:8'hDF]}) begin
               st_nxt.utf8_remaining = 2'd1;
               st_nxt.second_rule    = RULE_ANY;
            end else if (b == 8'hE0) begin
               st_nxt.utf8_remaining = 2'd2;
               st_nxt.second_rule    = RULE_E0;
            end else if (b == 8'hED) begin
               st_nxt.utf8_remaining = 2'd2;
               st_nxt.second_rule    = RULE_ED;
            end else if (b inside {[8'hE1:8'hEF]}) begin
               st_nxt.utf8_remaining = 2'd2;
               st_nxt.second_rule    = RULE_ANY;
            end else if (b == 8'hF0) begin
               st_nxt.utf8_remaining = 2'd3;
               st_nxt.second_rule    = RULE_F0;
            end else if (b == 8'hF4) begin
               st_nxt.utf8_remaining = 2'd3;
               st_nxt.second_rule    = RULE_F4;
            end else if (b inside {[8'hF1:8'hF3]}) begin
               st_nxt.utf8_remaining = 2'd3;
               st_nxt.second_rule    = RULE_ANY;
            end else begin
               st_nxt.sticky_error = ERR_BAD_UTF8;
               u8_emit             = 1'b0;
            end
         end
      end
      st_nxt.byte_parity = ~st.byte_parity;
   end

   // UTF-8 encoding of the joined code point, or the passthrough byte
   always_comb begin
      gen      = '0;
      gen.data = 1'b1;
      if (u8_emit) begin
         gen.cnt      = 3'd1;
         gen.bytes[0] = b;
      end else if (cp_emit) begin
         if (cp < 21'h80) begin
            gen.cnt      = 3'd1;
            gen.bytes[0] = {1'b0, cp[6:0]};
         end else if (cp < 21'h800) begin
            gen.cnt      = 3'd2;
            gen.bytes[0] = {3'b110, cp[10:6]};
            gen.bytes[1] = {2'b10, cp[5:0]};
         end else if (cp < 21'h10000) begin
            gen.cnt      = 3'd3;
            gen.bytes[0] = {4'b1110, cp[15:12]};
            gen.bytes[1] = {2'b10, cp[11:6]};
            gen.bytes[2] = {2'b10, cp[5:0]};
         end else begin
            gen.cnt      = 3'd4;
            gen.bytes[0] = {5'b11110, cp[20:18]};
            gen.bytes[1] = {2'b10, cp[17:12]};
            gen.bytes[2] = {2'b10, cp[11:6]};
            gen.bytes[3] = {2'b10, cp[5:0]};
         end
      end
   end

   // end-of-payload code, taken on the updated state
   always_comb begin
      if (mode == MODE_BAD_FORM) begin
         code = ERR_BAD_FORM;
      end else if (mode == MODE_BAD_LOC) begin
         code = ERR_BAD_LOC;
      end else if (mode != MODE_UTF8) begin
         if (st_nxt.byte_parity) code = ERR_ODD;
         else if (st_nxt.sticky_error != ERR_NONE) code = st_nxt.sticky_error;
         else if (st_nxt.have_high) code = ERR_TRUNC_HIGH;
         else code = ERR_NONE;
      end else begin
         if (st_nxt.sticky_error != ERR_NONE) code = st_nxt.sticky_error;
         else if (st_nxt.utf8_remaining != 2'd0) code = ERR_BAD_UTF8;
         else code = ERR_NONE;
      end
   end

   always_comb begin
      grp = gen;
      if (item.last) begin
         grp.last = 1'b1;
         grp.code = code;
         if (gen.cnt == 3'd0) begin
            grp.cnt  = 3'd1;
            grp.data = 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/char_lob_to_utf8_decoder_core.sv
`default_nettype none
// Channel  Direction  Handshake                     Beat
// req      in         req_valid / req_ready         req_data (data_byte, last)
// rsp      out        rsp_valid / rsp_ready         rsp_data (out_byte, byte_valid,
//                                                   out_last, error_code)
// csr      in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A req beat is held in the input register; its up to 4 result beats are then
// loaded into the result group register and leave one per cycle while rsp_ready
// is high. The single rsp port moves one byte per cycle, so the next req beat
// waits in the input register until the group has drained. A new req beat is taken while the
// last result of the previous group is still waiting. Reset is synchronous and
// clears registers, decoder state and both stages; rsp_ready low holds the group.
module char_lob_to_utf8_decoder_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  cl2u8_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output cl2u8_pkg::rsp_type   rsp_data,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire  [3:0]           paddr,
   input  wire  [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import cl2u8_pkg::*;

   cfg_type cfg_ff, cfg_in;
   st_type  st_ff, st_in, st_nxt;
   grp_type grp_ff, grp_in, grp_nxt;
   req_type in_data_ff, in_data_in;
   logic    in_vld_ff, in_vld_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] reg_idx;
   logic    wr;
   logic    take, at_end, grp_free, move, final_beat;

   // configuration port
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr      = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_idx)
            REG_FORM:  cfg_in.charset_form          = pwdata[7:0];
            REG_UTF16: cfg_in.locator_utf16         = pwdata[0];
            REG_LE:    cfg_in.locator_little_endian = pwdata[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FORM:  prdata = {24'd0, cfg_ff.charset_form};
         REG_UTF16: prdata = {31'd0, cfg_ff.locator_utf16};
         REG_LE:    prdata = {31'd0, cfg_ff.locator_little_endian};
         default:   prdata = 32'd0;
      endcase
   end

   // datapath
   cl2u8_step u_step (
      .cfg    (cfg_ff),
      .st     (st_ff),
      .item   (in_data_ff),
      .st_nxt (st_nxt),
      .grp    (grp_nxt)
   );

   assign rsp_valid = grp_ff.cnt != 3'd0;
   assign take      = rsp_valid && rsp_ready;
   assign at_end    = {1'b0, idx_ff} == grp_ff.cnt - 3'd1;
   assign grp_free  = !rsp_valid || (take && at_end);
   assign move      = in_vld_ff && grp_free;
   assign req_ready = !in_vld_ff || move;

   assign final_beat          = grp_ff.last && at_end;
   assign rsp_data.out_byte   = grp_ff.data ? grp_ff.bytes[idx_ff] : 8'd0;
   assign rsp_data.byte_valid = grp_ff.data;
   assign rsp_data.out_last   = final_beat;
   assign rsp_data.error_code = final_beat ? grp_ff.code : ERR_NONE;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_data_in = req_data;
      end else if (move) begin
         in_vld_in = 1'b0;
      end
      // end of payload: decoder state returns to its reset values
      st_in = st_ff;
      if (move && in_data_ff.last) begin
         st_in = '0;
      end else if (move) begin
         st_in = st_nxt;
      end
      grp_in = grp_ff;
      idx_in = idx_ff;
      if (move) begin
         grp_in = grp_nxt;
         idx_in = 2'd0;
      end else if (take && at_end) begin
         grp_in.cnt = 3'd0;
         idx_in     = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         st_ff     <= '0;
         grp_ff    <= '0;
         in_vld_ff <= 1'b0;
         idx_ff    <= 2'd0;
      end else begin
         cfg_ff    <= cfg_in;
         st_ff     <= st_in;
         grp_ff    <= grp_in;
         in_vld_ff <= in_vld_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cl2u8_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_BEATS   = 50;
   localparam int PHASES        = 10;

   typedef struct {
      logic [7:0] form;
      logic       utf16;
      logic       le;
      req_type    beat;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // register mirror
   logic [7:0]  form_q = FORM_LOCATOR0;
   logic        utf16_q = 1'b0;
   logic        le_q = 1'b0;

   // decoder state mirror
   logic [7:0]  held;
   logic        parity;
   logic [9:0]  high_bits;
   logic        high_pending;
   logic [1:0]  cont_left;
   logic [2:0]  lead_rule;
   logic [2:0]  first_err;

   rsp_type      utf8_due[$];
   rsp_type      step_out[$];
   logic [7:0]   enc_bytes[$];
   req_type      stim[$];
   stim_row_type rows[$];
   rsp_type      head;

   bit          steady = 1'b0;
   int          failures = 0;
   int          beats_in = 0;
   int          payloads = 0;
   int          beats_checked = 0;
   int          idle_cycles = 0;

   char_lob_to_utf8_decoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 25);
   end

   function automatic mode_type active_mode();
      if (form_q == FORM_UTF16BE) return MODE_BE;
      if (form_q != FORM_LOCATOR0 && form_q != FORM_LOCATOR1) return MODE_BAD_FORM;
      if (!utf16_q && le_q) return MODE_BAD_LOC;
      if (utf16_q) return le_q ? MODE_LE : MODE_BE;
      return MODE_UTF8;
   endfunction

   function automatic void add_enc(input logic [7:0] value);
      enc_bytes.insert(enc_bytes.size(), value);
   endfunction

   function automatic void utf8_encode(input logic [20:0] cp);
      enc_bytes.delete();
      if (cp < 21'h80) begin
         add_enc(cp[7:0]);
      end else if (cp < 21'h800) begin
         add_enc({3'b110, cp[10:6]});
         add_enc({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_enc({4'b1110, cp[15:12]});
         add_enc({2'b10, cp[11:6]});
         add_enc({2'b10, cp[5:0]});
      end else begin
         add_enc({5'b11110, cp[20:18]});
         add_enc({2'b10, cp[17:12]});
         add_enc({2'b10, cp[11:6]});
         add_enc({2'b10, cp[5:0]});
      end
   endfunction

   function automatic void clear_decoder();
      held = '0;
      parity = 1'b0;
      high_bits = '0;
      high_pending = 1'b0;
      cont_left = '0;
      lead_rule = RULE_NONE;
      first_err = ERR_NONE;
   endfunction

   // expected result beats of one input beat, left in step_out
   function automatic void transcode(input req_type beat);
      mode_type    m;
      logic [15:0] unit;
      logic [7:0]  b;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [2:0]  code;
      logic        ok;
      step_out.delete();
      enc_bytes.delete();
      m = active_mode();
      b = beat.data_byte;
      if (first_err == ERR_NONE) begin
         if (m == MODE_BAD_FORM || m == MODE_BAD_LOC) begin
            first_err = m;
         end else if (m != MODE_UTF8) begin
            if (!parity) begin
               held = b;
            end else begin
               unit = (m == MODE_BE) ? {held, b} : {b, held};
               if (high_pending) begin
                  high_pending = 1'b0;
                  if (unit < LOW_LO || unit > LOW_HI) first_err = ERR_BAD_LOW;
                  else utf8_encode(21'h10000 + {high_bits, unit[9:0]});
               end else if (unit >= HIGH_LO && unit <= HIGH_HI) begin
                  high_bits = unit[9:0];
                  high_pending = 1'b1;
               end else if (unit >= LOW_LO && unit <= LOW_HI) begin
                  first_err = ERR_LONE_LOW;
               end else begin
                  utf8_encode({5'd0, unit});
               end
            end
         end else if (cont_left != 0) begin
            case (lead_rule)
               RULE_E0: begin lo = 8'hA0; hi = 8'hBF; end
               RULE_ED: begin lo = 8'h80; hi = 8'h9F; end
               RULE_F0: begin lo = 8'h90; hi = 8'hBF; end
               RULE_F4: begin lo = 8'h80; hi = 8'h8F; end
               default: begin lo = 8'h80; hi = 8'hBF; end
            endcase
            if (b < lo || b > hi) begin
               first_err = ERR_BAD_UTF8;
            end else begin
               lead_rule = RULE_NONE;
               cont_left = cont_left - 2'd1;
               add_enc(b);
            end
         end else if (b <= 8'h7F) begin
            add_enc(b);
         end else begin
            ok = 1'b1;
            if (b >= 8'hC2 && b <= 8'hDF) {cont_left, lead_rule} = {2'd1, RULE_ANY};
            else if (b == 8'hE0) {cont_left, lead_rule} = {2'd2, RULE_E0};
            else if (b == 8'hED) {cont_left, lead_rule} = {2'd2, RULE_ED};
            else if (b >= 8'hE1 && b <= 8'hEF) {cont_left, lead_rule} = {2'd2, RULE_ANY};
            else if (b == 8'hF0) {cont_left, lead_rule} = {2'd3, RULE_F0};
            else if (b == 8'hF4) {cont_left, lead_rule} = {2'd3, RULE_F4};
            else if (b >= 8'hF1 && b <= 8'hF3) {cont_left, lead_rule} = {2'd3, RULE_ANY};
            else ok = 1'b0;
            if (ok) add_enc(b);
            else first_err = ERR_BAD_UTF8;
         end
      end
      parity = ~parity;
      foreach (enc_bytes[i])
         step_out.insert(step_out.size(), '{enc_bytes[i], 1'b1, 1'b0, ERR_NONE});
      if (beat.last) begin
         if (m == MODE_BAD_FORM || m == MODE_BAD_LOC) code = m;
         else if (m != MODE_UTF8)
            code = parity ? ERR_ODD : (first_err != ERR_NONE ? first_err :
                   (high_pending ? ERR_TRUNC_HIGH : ERR_NONE));
         else
            code = first_err != ERR_NONE ? first_err :
                   (cont_left != 0 ? ERR_BAD_UTF8 : ERR_NONE);
         if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].out_last = 1'b1;
            step_out[step_out.size() - 1].error_code = code;
         end else begin
            step_out.insert(0, '{8'h00, 1'b0, 1'b1, code});
         end
         clear_decoder();
      end
   endfunction

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_beat(input req_type beat, input logic typed, input rsp_type want);
      while (!steady && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_in++;
      if (beat.last) payloads++;
      transcode(beat);
      if (typed) utf8_due.insert(utf8_due.size(), want);
      else foreach (step_out[i]) utf8_due.insert(utf8_due.size(), step_out[i]);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input logic [7:0] form, input logic utf16, input logic le);
      req_valid <= 1'b0;
      @(posedge clock);
      while (utf8_due.size() != 0) @(posedge clock);
      // a beat with no result may still sit in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_FORM, {24'd0, form});
      csr_write(REG_UTF16, {31'd0, utf16});
      csr_write(REG_LE, {31'd0, le});
      form_q  = form;
      utf16_q = utf16;
      le_q    = le;
   endtask

   task automatic plan(input logic [7:0] form, input logic utf16, input logic le,
                       input logic [7:0] data, input logic last, input logic typed,
                       input logic [7:0] ob, input logic bv, input logic ol,
                       input logic [2:0] code);
      stim_row_type r;
      r.form  = form;
      r.utf16 = utf16;
      r.le    = le;
      r.beat  = '{data, last};
      r.typed = typed;
      r.want  = '{ob, bv, ol, code};
      rows.insert(rows.size(), r);
   endtask

   function automatic logic [20:0] pick_cp();
      int r;
      case ($urandom_range(4))
         0: return 21'($urandom_range(8'h7F));
         1: return 21'($urandom_range(12'h080, 12'h7FF));
         2: begin
            r = $urandom_range(16'h0800, 16'hF7FF);
            if (r >= 16'hD800) r += 16'h800;
            return 21'(r);
         end
         3: return 21'($urandom_range(32'h10000, 32'h10FFFF));
         default: begin
            case ($urandom_range(8))
               0: return 21'h7F;
               1: return 21'h80;
               2: return 21'h7FF;
               3: return 21'h800;
               4: return 21'hD7FF;
               5: return 21'hE000;
               6: return 21'hFFFF;
               7: return 21'h10000;
               default: return 21'h10FFFF;
            endcase
         end
      endcase
   endfunction

   // one payload in the current encoding, mostly well formed
   task automatic make_payload();
      mode_type    m;
      int          kind;
      logic [20:0] cp;
      logic [15:0] units[$];
      logic [7:0]  raw[$];
      req_type     beat;
      m = active_mode();
      if ($urandom_range(9) == 0 || m == MODE_BAD_FORM || m == MODE_BAD_LOC) begin
         repeat ($urandom_range(1, 6)) raw.insert(raw.size(), 8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 5)) begin
            cp = pick_cp();
            kind = $urandom_range(15);
            if (m == MODE_UTF8) begin
               utf8_encode(cp);
               if (kind == 0) enc_bytes[0] = 8'($urandom_range(8'h80, 8'hFF));
               else if (kind == 1 && enc_bytes.size() > 1) void'(enc_bytes.pop_back());
               foreach (enc_bytes[i]) raw.insert(raw.size(), enc_bytes[i]);
            end else if (kind == 0) begin
               units.insert(units.size(), LOW_LO + 16'($urandom_range(1023)));
            end else if (kind == 1) begin
               units.insert(units.size(), HIGH_LO + 16'($urandom_range(1023)));
            end else if (cp < 21'h10000) begin
               units.insert(units.size(), cp[15:0]);
            end else begin
               cp = cp - 21'h10000;
               units.insert(units.size(), HIGH_LO + {6'd0, cp[19:10]});
               units.insert(units.size(), LOW_LO + {6'd0, cp[9:0]});
            end
         end
         foreach (units[i]) begin
            if (m == MODE_LE) begin
               raw.insert(raw.size(), units[i][7:0]);
               raw.insert(raw.size(), units[i][15:8]);
            end else begin
               raw.insert(raw.size(), units[i][15:8]);
               raw.insert(raw.size(), units[i][7:0]);
            end
         end
         if (m != MODE_UTF8 && $urandom_range(7) == 0)
            raw.insert(raw.size(), 8'($urandom_range(255)));
         if (raw.size() == 0) raw.insert(0, 8'($urandom_range(255)));
      end
      foreach (raw[i]) begin
         beat.data_byte = raw[i];
         beat.last = (i == raw.size() - 1);
         stim.insert(stim.size(), beat);
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_checked++;
         if (utf8_due.size() == 0) begin
            $error("result beat %h with nothing expected", rsp_data);
            failures++;
         end else begin
            head = utf8_due.pop_front();
            check_field("out_byte", head.out_byte, rsp_data.out_byte);
            check_field("byte_valid", {7'd0, head.byte_valid}, {7'd0, rsp_data.byte_valid});
            check_field("out_last", {7'd0, head.out_last}, {7'd0, rsp_data.out_last});
            check_field("error_code", {5'd0, head.error_code}, {5'd0, rsp_data.error_code});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      logic [7:0] form;
      clear_decoder();

      // reset state: UTF-8 passthrough
      plan(FORM_LOCATOR0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR0, 1'b0, 1'b0, 8'h7F, 1'b1, 1'b1, 8'h7F, 1'b1, 1'b1, ERR_NONE);
      plan(FORM_LOCATOR0, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_BAD_UTF8);
      plan(FORM_LOCATOR0, 1'b0, 1'b0, 8'hE0, 1'b0, 1'b1, 8'hE0, 1'b1, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR0, 1'b0, 1'b0, 8'h9F, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_BAD_UTF8);
      plan(FORM_LOCATOR0, 1'b0, 1'b0, 8'hF4, 1'b1, 1'b1, 8'hF4, 1'b1, 1'b1, ERR_BAD_UTF8);
      // forced big endian
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'h41, 1'b1, 1'b1, 8'h41, 1'b1, 1'b1, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'hD8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'h3D, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'hDE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'hDC, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_LONE_LOW);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_ODD);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'hD8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_UTF16BE, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_TRUNC_HIGH);
      // little endian via locator
      plan(FORM_LOCATOR1, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR1, 1'b1, 1'b1, 8'hD8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR1, 1'b1, 1'b1, 8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
      plan(FORM_LOCATOR1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_BAD_LOW);
      // unsupported settings
      plan(FORM_LOCATOR0, 1'b0, 1'b1, 8'h55, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_BAD_LOC);
      plan(8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_BAD_FORM);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].form != form_q || rows[i].utf16 != utf16_q || rows[i].le != le_q)
            set_mode(rows[i].form, rows[i].utf16, rows[i].le);
         send_beat(rows[i].beat, rows[i].typed, rows[i].want);
      end

      // phases may end mid-payload; the new mode then sees the old state
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: set_mode(FORM_LOCATOR1, 1'b0, 1'b0);
            1: set_mode(FORM_LOCATOR0, 1'b1, 1'b0);
            2: set_mode(FORM_LOCATOR1, 1'b1, 1'b1);
            3: set_mode(FORM_UTF16BE, 1'b0, 1'b1);
            4: set_mode(8'($urandom_range(3, 255)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
            5: set_mode(FORM_LOCATOR0, 1'b0, 1'b1);
            default: begin
               case ($urandom_range(9))
                  0, 1, 2: set_mode(8'($urandom_range(1)), 1'b1, 1'($urandom_range(1)));
                  3, 4: set_mode(FORM_UTF16BE, 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
                  5, 6: set_mode(8'($urandom_range(1)), 1'b0, 1'b0);
                  7: set_mode(8'($urandom_range(3, 255)), 1'($urandom_range(1)), 1'b0);
                  8: set_mode(8'($urandom_range(1)), 1'b0, 1'b1);
                  default: begin
                     form = 8'($urandom_range(255));
                     set_mode(form, 1'($urandom_range(1)), 1'($urandom_range(1)));
                  end
               endcase
            end
         endcase
         steady = (ph == 6 || ph == 7);
         repeat (PHASE_BEATS) begin
            if (stim.size() == 0) make_payload();
            send_beat(stim.pop_front(), 1'b0, '0);
         end
      end
      steady = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (utf8_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d input beats in %0d payloads, %0d result beats checked", beats_in,
               payloads, beats_checked);
      $display("modes: UTF-8 check, UTF-16 BE/LE, bad form and bad locator settings");
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/cl2u8_pkg.sv
rtl/cl2u8_step.sv
rtl/char_lob_to_utf8_decoder_core.sv
tb/testbench.sv
